/* rtl/servo_bus_instruction_packet_framer_macros.svh */
// Assertion macros shared by the packet framer RTL.
// No dependencies; each file that asserts includes this header.
`ifndef SERVO_BUS_INSTRUCTION_PACKET_FRAMER_MACROS_SVH
`define SERVO_BUS_INSTRUCTION_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SBF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SBF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer assertion failed");

`endif

/* rtl/sbf_pkg.sv */
// Types, codes and the CRC step function of the servo-bus packet framer.
// No dependencies; used by every module of the framer.
package sbf_pkg;

   // Request codes.
   localparam logic [2:0] REQ_PING    = 3'd0;
   localparam logic [2:0] REQ_REBOOT  = 3'd1;
   localparam logic [2:0] REQ_READ    = 3'd2;
   localparam logic [2:0] REQ_WSTART  = 3'd3;
   localparam logic [2:0] REQ_PAYLOAD = 3'd4;
   localparam logic [2:0] REQ_WWORD   = 3'd5;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
   localparam logic [1:0] STATUS_SEQUENCE = 2'd2;

   // Instruction codes placed in the packet.
   localparam logic [7:0] INST_PING   = 8'h01;
   localparam logic [7:0] INST_READ   = 8'h02;
   localparam logic [7:0] INST_WRITE  = 8'h03;
   localparam logic [7:0] INST_REBOOT = 8'h08;

   // Job codes carried from the front end to the byte sequencer.
   localparam logic [2:0] JOB_ERROR   = 3'd0;
   localparam logic [2:0] JOB_PING    = 3'd1;
   localparam logic [2:0] JOB_REBOOT  = 3'd2;
   localparam logic [2:0] JOB_READ    = 3'd3;
   localparam logic [2:0] JOB_WSTART  = 3'd4;
   localparam logic [2:0] JOB_WWORD   = 3'd5;
   localparam logic [2:0] JOB_PAYLOAD = 3'd6;

   // Packet constants.
   localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
   localparam logic [7:0]  SYNC_MARK     = 8'hFD;
   localparam logic [7:0]  SYNC_RESERVED = 8'h00;
   localparam logic [15:0] CRC_POLY      = 16'h8005;
   localparam logic [15:0] LEN_SHORT     = 16'd3;
   localparam logic [15:0] LEN_READ      = 16'd7;
   localparam logic [15:0] LEN_WWORD     = 16'd9;
   localparam logic [15:0] LEN_WRITE_ADD = 16'd5;
   localparam logic [16:0] WRITE_OVERHEAD = 17'd12;
   localparam logic [16:0] WWORD_PACKET   = 17'd16;

   // Data bytes before the CRC for each job.
   localparam logic [4:0] NDATA_SINGLE = 5'd1;
   localparam logic [4:0] NDATA_SHORT  = 5'd8;
   localparam logic [4:0] NDATA_WSTART = 5'd10;
   localparam logic [4:0] NDATA_READ   = 5'd12;
   localparam logic [4:0] NDATA_WWORD  = 5'd14;
   localparam logic [4:0] CRC_BYTES    = 5'd2;

   // Queue between the front end and the sequencer.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  status;
      logic        crc_tail;
      logic [7:0]  servo_id;
      logic [15:0] reg_addr;
      logic [15:0] count;
      logic [7:0]  payload_byte;
      logic [31:0] data_word;
   } job_type;

   // One byte of CRC-16, MSB first, no reflection.
   function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

/* rtl/sbf_front.sv */
// Front end of the packet framer: accepts requests, checks sequence and length.
// Depends on sbf_pkg; feeds jobs to sbf_queue.
module sbf_front #(
   parameter int unsigned MAX_PACKET = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_type,
   input  logic [7:0]       req_servo_id,
   input  logic [15:0]      req_reg_addr,
   input  logic [15:0]      req_count,
   input  logic [7:0]       req_payload_byte,
   input  logic [31:0]      req_data_word,
   output logic             push_valid,
   output sbf_pkg::job_type push_job,
   input  logic             queue_full
);
   import sbf_pkg::*;

   logic       write_open_ff, write_open_in;
   logic [6:0] payload_left_ff, payload_left_in;
   logic [6:0] left_dec;
   logic [16:0] write_size;
   logic       req_xfer;

   // A request is taken whenever the queue has room.
   assign req_ready  = !queue_full;
   assign req_xfer   = req_valid && !queue_full;
   assign push_valid = req_xfer;

   assign left_dec   = payload_left_ff - 7'd1;
   assign write_size = {1'b0, req_count} + WRITE_OVERHEAD;

   // Classify the request against the open-write state.
   always_comb begin
      push_job.kind         = JOB_ERROR;
      push_job.status       = STATUS_SEQUENCE;
      push_job.crc_tail     = 1'b0;
      push_job.servo_id     = req_servo_id;
      push_job.reg_addr     = req_reg_addr;
      push_job.count        = req_count;
      push_job.payload_byte = req_payload_byte;
      push_job.data_word    = req_data_word;
      write_open_in         = write_open_ff;
      payload_left_in       = payload_left_ff;
      priority if (req_type == REQ_PAYLOAD) begin
         if (write_open_ff) begin
            push_job.kind     = JOB_PAYLOAD;
            push_job.status   = STATUS_OK;
            push_job.crc_tail = (left_dec == 7'd0);
            payload_left_in   = left_dec;
            if (left_dec == 7'd0) begin
               write_open_in = 1'b0;
            end
         end
      end else if (write_open_ff) begin
         // Any other request during a write is refused; the write stays open.
         push_job.kind = JOB_ERROR;
      end else begin
         unique case (req_type)
            REQ_PING: begin
               push_job.kind     = JOB_PING;
               push_job.status   = STATUS_OK;
               push_job.crc_tail = 1'b1;
            end
            REQ_REBOOT: begin
               push_job.kind     = JOB_REBOOT;
               push_job.status   = STATUS_OK;
               push_job.crc_tail = 1'b1;
            end
            REQ_READ: begin
               push_job.kind     = JOB_READ;
               push_job.status   = STATUS_OK;
               push_job.crc_tail = 1'b1;
            end
            REQ_WSTART: begin
               if (write_size > 17'(MAX_PACKET)) begin
                  push_job.status = STATUS_TOO_LONG;
               end else begin
                  push_job.kind     = JOB_WSTART;
                  push_job.status   = STATUS_OK;
                  push_job.crc_tail = (req_count == 16'd0);
                  if (req_count != 16'd0) begin
                     write_open_in   = 1'b1;
                     payload_left_in = req_count[6:0];
                  end
               end
            end
            REQ_WWORD: begin
               if (WWORD_PACKET > 17'(MAX_PACKET)) begin
                  push_job.status = STATUS_TOO_LONG;
               end else begin
                  push_job.kind     = JOB_WWORD;
                  push_job.status   = STATUS_OK;
                  push_job.crc_tail = 1'b1;
               end
            end
            default: begin
               push_job.kind = JOB_ERROR;
            end
         endcase
      end
   end

   // Write sequencing state.
   always_ff @(posedge clock) begin
      if (reset) begin
         write_open_ff   <= 1'b0;
         payload_left_ff <= 7'd0;
      end else if (req_xfer) begin
         write_open_ff   <= write_open_in;
         payload_left_ff <= payload_left_in;
      end
   end

endmodule

/* rtl/sbf_queue.sv */
// Four-entry job queue between the framer front end and byte sequencer.
// Depends on sbf_pkg.
module sbf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  sbf_pkg::job_type push_job,
   output logic             queue_full,
   input  logic             pop,
   output logic             head_valid,
   output sbf_pkg::job_type head_job
);
   import sbf_pkg::*;

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   fill_ff, fill_in;

   assign queue_full = (fill_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   // Fill level follows pushes and pops.
   always_comb begin
      fill_in = fill_ff;
      if (push_valid && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push_valid) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // Pointers and level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fill_ff <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/sbf_back.sv */
// Byte sequencer of the packet framer: expands jobs into packet bytes and CRC.
// Depends on sbf_pkg and the framer macro header; reads jobs from sbf_queue.
module sbf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  sbf_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_end_of_packet,
   output logic [1:0]       rsp_status
);
   import sbf_pkg::*;
`include "servo_bus_instruction_packet_framer_macros.svh"

   logic [3:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in, crc_base;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff, byte_in;
   logic        rsp_eop_ff, eop_in;
   logic [1:0]  rsp_status_ff;
   logic [4:0]  ndata, total;
   logic [15:0] pkt_len;
   logic [7:0]  inst, data_byte;
   logic        is_head, last, advance;

   // Shape of the packet for the job at the head of the queue.
   always_comb begin
      ndata   = NDATA_SINGLE;
      pkt_len = LEN_SHORT;
      inst    = INST_PING;
      is_head = 1'b1;
      unique case (head_job.kind)
         JOB_PING: begin
            ndata = NDATA_SHORT;
         end
         JOB_REBOOT: begin
            ndata = NDATA_SHORT;
            inst  = INST_REBOOT;
         end
         JOB_READ: begin
            ndata   = NDATA_READ;
            pkt_len = LEN_READ;
            inst    = INST_READ;
         end
         JOB_WSTART: begin
            ndata   = NDATA_WSTART;
            pkt_len = head_job.count + LEN_WRITE_ADD;
            inst    = INST_WRITE;
         end
         JOB_WWORD: begin
            ndata   = NDATA_WWORD;
            pkt_len = LEN_WWORD;
            inst    = INST_WRITE;
         end
         default: begin
            is_head = 1'b0;
         end
      endcase
   end

   assign total    = ndata + (head_job.crc_tail ? CRC_BYTES : 5'd0);
   assign last     = ({1'b0, idx_ff} == (total - 5'd1));
   assign crc_base = (idx_ff == 4'd0 && is_head) ? 16'd0 : crc_ff;
   assign advance  = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop      = advance && last;

   // Data byte at the current position of the packet.
   always_comb begin
      if (head_job.kind == JOB_PAYLOAD) begin
         data_byte = head_job.payload_byte;
      end else begin
         unique case (idx_ff)
            4'd0:    data_byte = SYNC_BYTE;
            4'd1:    data_byte = SYNC_BYTE;
            4'd2:    data_byte = SYNC_MARK;
            4'd3:    data_byte = SYNC_RESERVED;
            4'd4:    data_byte = head_job.servo_id;
            4'd5:    data_byte = pkt_len[7:0];
            4'd6:    data_byte = pkt_len[15:8];
            4'd7:    data_byte = inst;
            4'd8:    data_byte = head_job.reg_addr[7:0];
            4'd9:    data_byte = head_job.reg_addr[15:8];
            4'd10:   data_byte = (head_job.kind == JOB_READ) ? head_job.count[7:0]
                                                              : head_job.data_word[7:0];
            4'd11:   data_byte = (head_job.kind == JOB_READ) ? head_job.count[15:8]
                                                              : head_job.data_word[15:8];
            4'd12:   data_byte = head_job.data_word[23:16];
            default: data_byte = head_job.data_word[31:24];
         endcase
      end
   end

   // Output byte and CRC update: refusal, data byte, CRC low, CRC high.
   always_comb begin
      byte_in = data_byte;
      eop_in  = 1'b0;
      crc_in  = crc_ff;
      priority if (head_job.kind == JOB_ERROR) begin
         byte_in = 8'h00;
      end else if ({1'b0, idx_ff} < ndata) begin
         crc_in = crc_byte(crc_base, data_byte);
      end else if ({1'b0, idx_ff} == ndata) begin
         byte_in = crc_ff[7:0];
      end else begin
         byte_in = crc_ff[15:8];
         eop_in  = 1'b1;
         crc_in  = 16'd0;
      end
   end

   assign idx_in = last ? 4'd0 : idx_ff + 4'd1;

   // Sequencer control and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 4'd0;
         crc_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff   <= byte_in;
         rsp_eop_ff    <= eop_in;
         rsp_status_ff <= head_job.status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_end_of_packet = rsp_eop_ff;
   assign rsp_status        = rsp_status_ff;

   // A job part-way through its bytes stays at the head of the queue.
   `SBF_ASSERT_IMPL(a_busy_has_job, clock, reset, idx_ff != 4'd0, head_valid)
   // The last byte of a job returns the sequencer to the start position.
   `SBF_ASSERT_NEXT(a_last_rewinds, clock, reset, advance && last, idx_ff == 4'd0)
   // Other bytes step the position by one.
   `SBF_ASSERT_NEXT(a_step_by_one, clock, reset, advance && !last,
                    idx_ff == $past(idx_ff) + 4'd1)

endmodule

/* rtl/servo_bus_instruction_packet_framer.sv */
// Top level of the servo-bus instruction packet framer.
// Depends on sbf_pkg, sbf_front, sbf_queue and sbf_back.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   type, servo id, address, count, byte, word
//   rsp_      out        rsp_valid/rsp_ready   packet byte, end of packet, status
//
// The sequencer sends one packet byte per cycle unless the output stalls: ping and reboot
// packets are 10 bytes, read 14, write word 16, write start 10 (12 for an empty write),
// a payload byte 1 (3 for the last one) and a refused request 1; the byte sequencer sets this.
// Requests are taken every cycle while the four-entry job queue has room.
// Synchronous reset clears the write state, queue and sequencer.
// A stalled output holds its byte and halts the sequencer; the queue keeps taking
// requests until it is full, and then req_ready falls.
module servo_bus_instruction_packet_framer #(
   parameter int unsigned MAX_PACKET = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_servo_id,
   input  logic [15:0] req_reg_addr,
   input  logic [15:0] req_count,
   input  logic [7:0]  req_payload_byte,
   input  logic [31:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_packet,
   output logic [1:0]  rsp_status
);
   import sbf_pkg::*;

   logic    push_valid, queue_full, head_valid, pop;
   job_type push_job, head_job;

   // Request classification and write sequencing.
   sbf_front #(.MAX_PACKET(MAX_PACKET)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_servo_id     (req_servo_id),
      .req_reg_addr     (req_reg_addr),
      .req_count        (req_count),
      .req_payload_byte (req_payload_byte),
      .req_data_word    (req_data_word),
      .push_valid       (push_valid),
      .push_job         (push_job),
      .queue_full       (queue_full)
   );

   // Job queue.
   sbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .queue_full (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Byte sequencer and output register.
   sbf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_job          (head_job),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_packet (rsp_end_of_packet),
      .rsp_status        (rsp_status)
   );

endmodule

/* tb/tb_servo_bus_instruction_packet_framer.sv */
// Self-checking testbench for the servo-bus instruction packet framer.
// Depends on sbf_pkg and servo_bus_instruction_packet_framer; predicts every packet byte
// from the request stream and checks the byte stream that comes out.
module tb_servo_bus_instruction_packet_framer;
   timeunit 1ns;
   timeprecision 1ps;

   import sbf_pkg::*;

   localparam int unsigned FRAME_LIMIT = 128;
   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES = 20;

   // One expected byte of the output stream.
   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       eop;
      logic [1:0] status;
   } frame_byte_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_type;
   logic [7:0]  req_servo_id;
   logic [15:0] req_reg_addr;
   logic [15:0] req_count;
   logic [7:0]  req_payload_byte;
   logic [31:0] req_data_word;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_packet;
   logic [1:0]  rsp_status;

   // Shadow of the framer state, kept by the byte predictor.
   logic [15:0] frame_crc = 16'h0000;
   logic [6:0]  bytes_owed = 7'd0;
   logic        write_active = 1'b0;

   frame_byte_type expected_bytes[$];
   int unsigned fault_count = 0;
   int unsigned stall_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned rsp_hold_left = 0;

   servo_bus_instruction_packet_framer #(
      .MAX_PACKET(FRAME_LIMIT)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_servo_id      (req_servo_id),
      .req_reg_addr      (req_reg_addr),
      .req_count         (req_count),
      .req_payload_byte  (req_payload_byte),
      .req_data_word     (req_data_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_packet (rsp_end_of_packet),
      .rsp_status        (rsp_status)
   );

   // Free-running clock, 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Bit-serial CRC-16, polynomial 0x8005, MSB first.
   function automatic logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] data);
      logic feedback;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[15] ^ data[i];
         acc = {acc[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
      end
      return acc;
   endfunction

   function automatic void push_byte(logic [7:0] b, logic eop, logic [1:0] st);
      expected_bytes.push_back({b, eop, st});
   endfunction

   function automatic void push_data(logic [7:0] b);
      frame_crc = crc16_update(frame_crc, b);
      push_byte(b, 1'b0, STATUS_OK);
   endfunction

   // The CRC goes out low byte first and closes the packet.
   function automatic void push_crc();
      push_byte(frame_crc[7:0], 1'b0, STATUS_OK);
      push_byte(frame_crc[15:8], 1'b1, STATUS_OK);
      frame_crc = 16'h0000;
   endfunction

   function automatic void push_header(logic [7:0] id, logic [15:0] len, logic [7:0] inst);
      frame_crc = 16'h0000;
      push_data(SYNC_BYTE);
      push_data(SYNC_BYTE);
      push_data(SYNC_MARK);
      push_data(SYNC_RESERVED);
      push_data(id);
      push_data(len[7:0]);
      push_data(len[15:8]);
      push_data(inst);
   endfunction

   // Works out the bytes one accepted request produces and queues them.
   function automatic void predict_request(logic [2:0] kind, logic [7:0] id,
                                           logic [15:0] addr, logic [15:0] cnt,
                                           logic [7:0] pbyte, logic [31:0] word);
      if (kind == REQ_PAYLOAD) begin
         if (!write_active) begin
            push_byte(8'h00, 1'b0, STATUS_SEQUENCE);
         end else begin
            push_data(pbyte);
            bytes_owed = bytes_owed - 7'd1;
            if (bytes_owed == 7'd0) begin
               push_crc();
               write_active = 1'b0;
            end
         end
      end else if (kind > REQ_WWORD || write_active) begin
         push_byte(8'h00, 1'b0, STATUS_SEQUENCE);
      end else begin
         case (kind)
            REQ_PING: begin
               push_header(id, LEN_SHORT, INST_PING);
               push_crc();
            end
            REQ_REBOOT: begin
               push_header(id, LEN_SHORT, INST_REBOOT);
               push_crc();
            end
            REQ_READ: begin
               push_header(id, LEN_READ, INST_READ);
               push_data(addr[7:0]);
               push_data(addr[15:8]);
               push_data(cnt[7:0]);
               push_data(cnt[15:8]);
               push_crc();
            end
            REQ_WSTART: begin
               if ({1'b0, cnt} + WRITE_OVERHEAD > 17'(FRAME_LIMIT)) begin
                  push_byte(8'h00, 1'b0, STATUS_TOO_LONG);
               end else begin
                  push_header(id, cnt + LEN_WRITE_ADD, INST_WRITE);
                  push_data(addr[7:0]);
                  push_data(addr[15:8]);
                  if (cnt == 16'd0) begin
                     push_crc();
                  end else begin
                     bytes_owed = cnt[6:0];
                     write_active = 1'b1;
                  end
               end
            end
            default: begin
               if (WWORD_PACKET > 17'(FRAME_LIMIT)) begin
                  push_byte(8'h00, 1'b0, STATUS_TOO_LONG);
               end else begin
                  push_header(id, LEN_WWORD, INST_WRITE);
                  push_data(addr[7:0]);
                  push_data(addr[15:8]);
                  push_data(word[7:0]);
                  push_data(word[15:8]);
                  push_data(word[23:16]);
                  push_data(word[31:24]);
                  push_crc();
               end
            end
         endcase
      end
   endfunction

   function automatic void note_fault(string msg);
      fault_count++;
      $display("%0d ns: %s", $time, msg);
   endfunction

   // Offers one request from the falling edge, with random gaps, until it is taken.
   task automatic send_request(input logic [2:0] kind, input logic [7:0] id,
                               input logic [15:0] addr, input logic [15:0] cnt,
                               input logic [7:0] pbyte, input logic [31:0] word);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_type         = kind;
      req_servo_id     = id;
      req_reg_addr     = addr;
      req_count        = cnt;
      req_payload_byte = pbyte;
      req_data_word    = word;
      do @(posedge clock); while (!req_ready);
      predict_request(kind, id, addr, cnt, pbyte, word);
   endtask

   task automatic send_payload(input logic [7:0] pbyte);
      send_request(REQ_PAYLOAD, 8'($urandom()), 16'($urandom()), 16'($urandom()), pbyte,
                   $urandom());
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_for_drain();
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // Whole packets from a single request, with the field extremes.
   task automatic test_single_packets();
      send_request(REQ_PING, 8'h00, 16'h0000, 16'h0000, 8'h00, 32'h0000_0000);
      send_request(REQ_REBOOT, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      send_request(REQ_READ, 8'hA5, 16'hFFFF, 16'hFFFF, 8'h00, 32'h0000_0000);
      send_request(REQ_READ, 8'h5A, 16'h0000, 16'h0000, 8'hFF, 32'hFFFF_FFFF);
      send_request(REQ_WWORD, 8'h5A, 16'h1234, 16'h0000, 8'h00, 32'hFFFF_FFFF);
      send_request(REQ_WWORD, 8'hFE, 16'hFFFF, 16'hFFFF, 8'hFF, 32'h0000_0000);
      stop_sending();
   endtask

   // Stray payload bytes, unused request codes and oversized writes.
   task automatic test_refused_requests();
      send_payload(8'hC3);
      send_request(3'd6, 8'h11, 16'h2222, 16'h0003, 8'h44, 32'h5555_5555);
      send_request(3'd7, 8'hEE, 16'hDDDD, 16'h0004, 8'hBB, 32'hAAAA_AAAA);
      send_request(REQ_WSTART, 8'h01, 16'h0010, 16'(FRAME_LIMIT - 11), 8'h00, 32'h0);
      send_request(REQ_WSTART, 8'h02, 16'h0020, 16'hFFFF, 8'h00, 32'h0);
      stop_sending();
   endtask

   // Empty write, and headers arriving while a write is still open.
   task automatic test_write_framing();
      send_request(REQ_WSTART, 8'h03, 16'h0084, 16'h0000, 8'h00, 32'h0);
      send_request(REQ_WSTART, 8'h04, 16'h0074, 16'h0003, 8'h00, 32'h0);
      send_request(REQ_PING, 8'h05, 16'h0000, 16'h0000, 8'h00, 32'h0);
      send_request(REQ_WSTART, 8'h06, 16'h0001, 16'h0002, 8'h00, 32'h0);
      send_request(REQ_WWORD, 8'h07, 16'h0002, 16'h0000, 8'h00, 32'h1234_5678);
      send_request(REQ_READ, 8'h08, 16'h0003, 16'h0004, 8'h00, 32'h0);
      send_payload(8'h00);
      send_payload(8'hFF);
      send_payload(8'h80);
      stop_sending();
   endtask

   // The largest write that still fits in a packet.
   task automatic test_longest_write();
      send_request(REQ_WSTART, 8'h7E, 16'hFFFF, 16'(FRAME_LIMIT - 12), 8'h00, 32'h0);
      for (int k = 0; k < FRAME_LIMIT - 12; k++) begin
         send_payload(8'($urandom()));
      end
      stop_sending();
   endtask

   // Mostly well-formed writes with random content, mixed with headers and noise.
   // Refused requests do not count towards the item total.
   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned sent_here;
      int unsigned pick;
      int unsigned len;
      logic [2:0]  kind;
      sent_here = 0;
      while (sent_here < n_items) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(FRAME_LIMIT - 12, 9)
                                            : $urandom_range(8, 0);
            send_request(REQ_WSTART, 8'($urandom()), 16'($urandom()), 16'(len),
                         8'($urandom()), $urandom());
            sent_here++;
            for (int k = 0; k < len; k++) begin
               // Now and then a header cuts into the open write.
               if ($urandom_range(19) == 0) begin
                  kind = 3'($urandom_range(6));
                  if (kind >= REQ_PAYLOAD) kind = kind + 3'd1;
                  send_request(kind, 8'($urandom()), 16'($urandom()), 16'($urandom()),
                               8'($urandom()), $urandom());
               end
               send_payload(8'($urandom()));
               sent_here++;
            end
         end else if (pick < 75) begin
            case ($urandom_range(3))
               0: kind = REQ_PING;
               1: kind = REQ_REBOOT;
               2: kind = REQ_READ;
               default: kind = REQ_WWORD;
            endcase
            send_request(kind, 8'($urandom()), 16'($urandom()), 16'($urandom()),
                         8'($urandom()), $urandom());
            sent_here++;
         end else if (pick < 85) begin
            send_request(REQ_WSTART, 8'($urandom()), 16'($urandom()),
                         16'($urandom_range(65535, FRAME_LIMIT - 11)), 8'($urandom()),
                         $urandom());
         end else if (pick < 92) begin
            send_payload(8'($urandom()));
         end else begin
            send_request(3'($urandom_range(7, 6)), 8'($urandom()), 16'($urandom()),
                         16'($urandom()), 8'($urandom()), $urandom());
         end
      end
      stop_sending();
   endtask

   // The receiver holds off for a long stretch while reads keep coming,
   // so the job queue fills and the input stalls.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      rsp_hold_left = 400;
      for (int k = 0; k < 10; k++) begin
         send_request(REQ_READ, 8'($urandom()), 16'($urandom()), 16'($urandom()),
                      8'($urandom()), $urandom());
      end
      stop_sending();
   endtask

   // The sender pauses mid-write until every byte so far has come out.
   task automatic test_drain_pause();
      send_idle_pct = 10;
      recv_idle_pct = 10;
      send_request(REQ_WSTART, 8'($urandom()), 16'($urandom()), 16'd5, 8'($urandom()),
                   $urandom());
      send_payload(8'($urandom()));
      send_payload(8'($urandom()));
      stop_sending();
      wait_for_drain();
      send_payload(8'($urandom()));
      send_payload(8'($urandom()));
      send_payload(8'($urandom()));
      send_request(REQ_PING, 8'($urandom()), 16'($urandom()), 16'($urandom()),
                   8'($urandom()), $urandom());
      stop_sending();
   endtask

   // Receiver: ready changes on the falling edge; a hold-off overrides the random idling.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready = 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Each byte transfer is checked against the oldest expected byte.
   always @(posedge clock) begin : check_bytes
      frame_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            note_fault($sformatf("unexpected byte: out_byte %02h end_of_packet %0b status %0d",
                                 rsp_out_byte, rsp_end_of_packet, rsp_status));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.pkt_byte) begin
               note_fault($sformatf("out_byte: expected %02h, actual %02h",
                                    want.pkt_byte, rsp_out_byte));
            end
            if (rsp_end_of_packet !== want.eop) begin
               note_fault($sformatf("end_of_packet: expected %0b, actual %0b",
                                    want.eop, rsp_end_of_packet));
            end
            if (rsp_status !== want.status) begin
               note_fault($sformatf("status: expected %0d, actual %0d",
                                    want.status, rsp_status));
            end
         end
      end
   end

   // Watchdog: too long without any transfer on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0d ns: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb_servo_bus_instruction_packet_framer: FAIL");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_PING;
      req_servo_id     = 8'h00;
      req_reg_addr     = 16'h0000;
      req_count        = 16'h0000;
      req_payload_byte = 8'h00;
      req_data_word    = 32'h0000_0000;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 10;
      recv_idle_pct = 30;
      test_single_packets();
      test_refused_requests();
      test_write_framing();
      test_longest_write();

      send_idle_pct = 18;
      recv_idle_pct = 74;
      test_random_traffic(20);
      send_idle_pct = 74;
      recv_idle_pct = 18;
      test_random_traffic(20);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(10);

      test_output_backpressure();
      test_drain_pause();

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb_servo_bus_instruction_packet_framer: PASS");
      end else begin
         $display("tb_servo_bus_instruction_packet_framer: FAIL");
      end
      $finish;
   end

endmodule
